// File: design/matrix_inverse_cofactor_defines.svh
// ----------------------------------------------------------------------------
// Matrix inverse assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_COFACTOR_DEFINES_SVH
`define MATRIX_INVERSE_COFACTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MIC_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define MIC_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define MIC_ASSERT_IMP(name, clk, rst_n, pre, post)
`define MIC_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif
`endif

// File: design/mic_pkg.sv
// ----------------------------------------------------------------------------
// Matrix inverse package
// Shared value type, status structs and magnitude helper.
// ----------------------------------------------------------------------------
package mic_pkg;

    localparam int VAL_W = 64;
    localparam int OUT_W = 32;
    localparam int IDX_W = 2;

    typedef logic signed [VAL_W-1:0] t_val;

    localparam t_val VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

    function automatic logic [VAL_W-1:0] mag(t_val a);
        return a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
    endfunction

endpackage

// File: design/mic_mul.sv
// ----------------------------------------------------------------------------
// Serial fixed-point multiplier
// Shift-add over one multiplier bit per cycle, then scale and saturate.
// ----------------------------------------------------------------------------
module mic_mul import mic_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_val       i_a,
    input  t_val       i_b,
    output t_unit_stat o_stat,
    output t_val       o_prod
);

    logic [VAL_W-1:0]   r_cand;
    logic [VAL_W-1:0]   r_plier;
    logic [VAL_W-1:0]   r_hi;
    logic [VAL_W-1:0]   r_lo;
    logic [5:0]         r_cnt;
    logic               r_neg;
    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    t_val               r_prod;

    logic [VAL_W:0]     w_sum;
    logic [2*VAL_W-1:0] w_full;
    logic [2*VAL_W-1:0] w_q;
    logic               w_ovf;
    t_val               w_m;

    assign w_sum  = {1'b0, r_hi} + (r_plier[0] ? {1'b0, r_cand} : '0);
    assign w_full = {r_hi, r_lo};
    assign w_q    = w_full >> FRAC_BITS;
    assign w_ovf  = |w_full[2*VAL_W-1:VAL_W-1+FRAC_BITS];
    assign w_m    = w_ovf ? VAL_MAX : t_val'({1'b0, w_q[VAL_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_cand  <= mag(i_a);
                r_plier <= mag(i_b);
                r_neg   <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
                r_hi    <= '0;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_hi    <= w_sum[VAL_W:1];
                r_lo    <= {w_sum[0], r_lo[VAL_W-1:1]};
                r_plier <= r_plier >> 1;
                r_cnt   <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_prod <= r_neg ? -w_m : w_m;
            end
        end
    end

    assign o_stat = '{busy: r_busy | r_fin, done: r_done};
    assign o_prod = r_prod;

endmodule

// File: design/mic_div.sv
// ----------------------------------------------------------------------------
// Serial fixed-point divider
// Restoring division, one quotient bit per cycle, clipped to element range.
// ----------------------------------------------------------------------------
module mic_div import mic_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  t_val                         i_num,
    input  t_val                         i_den,
    output t_div_stat                    o_stat,
    output logic signed [ELEM_WIDTH-1:0] o_value
);

    localparam logic [VAL_W-1:0] HALF = VAL_W'(1) << (ELEM_WIDTH - 1);

    logic [2*VAL_W-1:0]          r_dvd;
    logic [VAL_W-1:0]            r_den;
    logic [VAL_W-1:0]            r_rem;
    logic [VAL_W-1:0]            r_q;
    logic                        r_over;
    logic                        r_neg;
    logic [6:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_fin;
    logic                        r_done;
    logic                        r_sat;
    logic signed [ELEM_WIDTH-1:0] r_res;

    logic [VAL_W-1:0] w_rr;
    logic             w_ge;

    assign w_rr = {r_rem[VAL_W-2:0], r_dvd[2*VAL_W-1]};
    assign w_ge = (w_rr >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_dvd  <= (2*VAL_W)'(mag(i_num)) << FRAC_BITS;
                r_den  <= mag(i_den);
                r_neg  <= i_num[VAL_W-1] ^ i_den[VAL_W-1];
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_rr - r_den) : w_rr;
                r_q    <= {r_q[VAL_W-2:0], w_ge};
                r_over <= r_over | r_q[VAL_W-1];
                r_dvd  <= r_dvd << 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                if (r_neg) begin
                    if (r_over || r_q > HALF) begin
                        r_sat <= 1'b1;
                        r_res <= ELEM_WIDTH'(-HALF);
                    end else begin
                        r_sat <= 1'b0;
                        r_res <= ELEM_WIDTH'(-r_q);
                    end
                end else begin
                    if (r_over || r_q > HALF - 1'b1) begin
                        r_sat <= 1'b1;
                        r_res <= ELEM_WIDTH'(HALF - 1'b1);
                    end else begin
                        r_sat <= 1'b0;
                        r_res <= ELEM_WIDTH'(r_q);
                    end
                end
            end
        end
    end

    assign o_stat  = '{done: r_done, sat: r_sat};
    assign o_value = r_res;

endmodule

// File: design/matrix_inverse_cofactor.sv
// ----------------------------------------------------------------------------
// Matrix inverse by cofactors
// Loads a DIM x DIM fixed-point matrix, expands the determinant along row 0
// and emits the adjugate over the determinant, one element per beat.
//
//   channel  signals                             direction  beat
//   input    i_in_valid / o_in_ready             in         one element
//   output   o_out_valid / i_out_ready           out        one inverse element
//
// Elements load in row-major order. After the last element the block
// runs a serial multiplier and a serial divider: a 4x4 needs 40 products
// for the determinant and, unless the determinant is zero, 9 products plus
// one quotient per element. Reset is synchronous, active low. A stalled
// output holds the sequencer in its emit step; the input is taken again
// once the last beat is queued.
// ----------------------------------------------------------------------------
`include "matrix_inverse_cofactor_defines.svh"

module matrix_inverse_cofactor import mic_pkg::*; #(
    parameter int DIM        = 4,
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [OUT_W-1:0] i_element_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OUT_W-1:0] o_inverse_value,
    output logic [IDX_W-1:0] o_out_row,
    output logic [IDX_W-1:0] o_out_col,
    output logic             o_singular,
    output logic             o_saturated,
    output logic             o_last_result
);

    localparam int NELEM = DIM * DIM;
    localparam int IW    = $clog2(NELEM);
    localparam int RW    = $clog2(DIM);
    localparam int SW    = $clog2(DIM + 1);

    typedef enum logic [11:0] {
        S_LOAD  = 12'h001,
        S_DET   = 12'h002,
        S_COF   = 12'h004,
        S_ENTER = 12'h008,
        S_NODE  = 12'h010,
        S_RDA   = 12'h020,
        S_RDB   = 12'h040,
        S_RDB2  = 12'h080,
        S_MULW  = 12'h100,
        S_RET   = 12'h200,
        S_DIVW  = 12'h400,
        S_EMIT  = 12'h800
    } t_state;

    t_state                  r_state;
    logic [IW-1:0]           r_ld;
    logic [ELEM_WIDTH-1:0]   r_mem [NELEM];
    logic [ELEM_WIDTH-1:0]   r_rd;
    logic [RW-1:0]           r_lvl;
    logic [SW-1:0]           r_n;
    logic                    r_xen;
    logic [RW-1:0]           r_xrow;
    t_val                    r_acc [DIM];
    logic [DIM-1:0]          r_mask [DIM];
    logic [SW-1:0]           r_pos [DIM];
    logic                    r_half;
    t_val                    r_val;
    t_val                    r_opa;
    logic                    r_cof;
    logic                    r_sing;
    t_val                    r_det;
    logic [RW-1:0]           r_orow;
    logic [RW-1:0]           r_ocol;
    logic signed [ELEM_WIDTH-1:0] r_q;
    logic                    r_qsat;

    logic [SW-1:0]           w_s;
    logic [DIM-1:0]          w_mask;
    logic [SW-1:0]           w_pos;
    logic [RW-1:0]           w_r0;
    logic [RW-1:0]           w_r1;
    logic [RW-1:0]           w_c0;
    logic [RW-1:0]           w_c1;
    logic [RW-1:0]           w_ck;
    logic [IW-1:0]           w_addr;
    t_val                    w_rdv;
    logic                    w_mstart;
    t_val                    w_ma;
    t_val                    w_mb;
    t_unit_stat              w_mstat;
    t_val                    w_prod;
    logic                    w_dstart;
    t_val                    w_num;
    t_div_stat               w_dstat;
    logic signed [ELEM_WIDTH-1:0] w_dval;
    logic                    w_slot;
    logic                    w_olast;
    logic                    w_in_acc;

    function automatic logic [RW-1:0] col_at(logic [DIM-1:0] m, logic [SW-1:0] p);
        logic [SW-1:0] cnt;
        logic [RW-1:0] res;
        cnt = '0;
        res = '0;
        for (int j = 0; j < DIM; j++) begin
            if (m[j]) begin
                if (cnt == p) begin
                    res = RW'(j);
                end
                cnt = cnt + 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [RW-1:0] row_of(logic [RW-1:0] l, logic xen, logic [RW-1:0] xr);
        logic [RW:0] t;
        t = {1'b0, l};
        if (xen && l >= xr) begin
            t = t + 1'b1;
        end
        return t[RW-1:0];
    endfunction

    function automatic logic [IW-1:0] e_addr(logic [RW-1:0] r, logic [RW-1:0] c);
        return IW'(int'(r) * DIM + int'(c));
    endfunction

    function automatic t_val sat_add(t_val a, t_val b);
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        if (s > (VAL_W+1)'(VAL_MAX)) begin
            return VAL_MAX;
        end
        if (s < -((VAL_W+1)'(VAL_MAX))) begin
            return -VAL_MAX;
        end
        return t_val'(s[VAL_W-1:0]);
    endfunction

    assign w_s      = r_n - SW'(r_lvl);
    assign w_mask   = r_mask[r_lvl];
    assign w_pos    = r_pos[r_lvl];
    assign w_r0     = row_of(r_lvl, r_xen, r_xrow);
    assign w_r1     = row_of(r_lvl + 1'b1, r_xen, r_xrow);
    assign w_c0     = col_at(w_mask, SW'(0));
    assign w_c1     = col_at(w_mask, SW'(1));
    assign w_ck     = col_at(w_mask, w_pos);
    assign w_rdv    = VAL_W'(signed'(r_rd));
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_slot   = !o_out_valid || i_out_ready;
    assign w_olast  = (r_orow == RW'(DIM - 1)) && (r_ocol == RW'(DIM - 1));

    always_comb begin
        w_addr = '0;
        unique case (r_state)
            S_RDA: begin
                if (w_s == SW'(1)) begin
                    w_addr = e_addr(w_r0, w_c0);
                end else if (w_s == SW'(2)) begin
                    w_addr = r_half ? e_addr(w_r0, w_c1) : e_addr(w_r0, w_c0);
                end else begin
                    w_addr = e_addr(w_r0, w_ck);
                end
            end
            S_RDB: begin
                w_addr = r_half ? e_addr(w_r1, w_c0) : e_addr(w_r1, w_c1);
            end
            default: begin
                w_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem[r_ld] <= i_element_value[ELEM_WIDTH-1:0];
        end
        r_rd <= r_mem[w_addr];
    end

    assign w_mstart = ((r_state == S_RDB) && (w_s > SW'(2))) || (r_state == S_RDB2);
    assign w_ma     = (r_state == S_RDB) ? w_rdv : r_opa;
    assign w_mb     = (r_state == S_RDB) ? r_val : w_rdv;
    assign w_dstart = (r_state == S_RET) && (r_lvl == '0) && r_cof;
    assign w_num    = (r_orow[0] ^ r_ocol[0]) ? -r_val : r_val;

    mic_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_stat  (w_mstat),
        .o_prod  (w_prod)
    );

    mic_div #(
        .FRAC_BITS  (FRAC_BITS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_num),
        .i_den   (r_det),
        .o_stat  (w_dstat),
        .o_value (w_dval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ld        <= '0;
            r_lvl       <= '0;
            r_orow      <= '0;
            r_ocol      <= '0;
            r_cof       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && r_state != S_EMIT) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_ld == IW'(NELEM - 1)) begin
                            r_ld    <= '0;
                            r_state <= S_DET;
                        end else begin
                            r_ld <= r_ld + 1'b1;
                        end
                    end
                end
                S_DET: begin
                    r_n       <= SW'(DIM);
                    r_xen     <= 1'b0;
                    r_xrow    <= '0;
                    r_lvl     <= '0;
                    r_mask[0] <= {DIM{1'b1}};
                    r_cof     <= 1'b0;
                    r_orow    <= '0;
                    r_ocol    <= '0;
                    r_state   <= S_ENTER;
                end
                S_COF: begin
                    r_n       <= SW'(DIM - 1);
                    r_xen     <= 1'b1;
                    r_xrow    <= r_ocol;
                    r_lvl     <= '0;
                    r_mask[0] <= {DIM{1'b1}} & ~(DIM'(1) << r_orow);
                    r_cof     <= 1'b1;
                    r_state   <= S_ENTER;
                end
                S_ENTER: begin
                    r_acc[r_lvl] <= '0;
                    r_pos[r_lvl] <= '0;
                    r_half       <= 1'b0;
                    r_state      <= S_NODE;
                end
                S_NODE: begin
                    if (w_s <= SW'(2)) begin
                        r_state <= S_RDA;
                    end else if (w_pos == w_s) begin
                        r_val   <= r_acc[r_lvl];
                        r_state <= S_RET;
                    end else begin
                        r_mask[r_lvl + 1'b1] <= w_mask & ~(DIM'(1) << w_ck);
                        r_lvl                <= r_lvl + 1'b1;
                        r_state              <= S_ENTER;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    if (w_s == SW'(1)) begin
                        r_val   <= w_rdv;
                        r_state <= S_RET;
                    end else if (w_s == SW'(2)) begin
                        r_opa   <= w_rdv;
                        r_state <= S_RDB2;
                    end else begin
                        r_state <= S_MULW;
                    end
                end
                S_RDB2: begin
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    if (w_mstat.done) begin
                        if (w_s == SW'(2)) begin
                            if (!r_half) begin
                                r_val   <= w_prod;
                                r_half  <= 1'b1;
                                r_state <= S_RDA;
                            end else begin
                                r_val   <= sat_add(r_val, -w_prod);
                                r_state <= S_RET;
                            end
                        end else begin
                            r_acc[r_lvl] <= sat_add(r_acc[r_lvl],
                                                    w_pos[0] ? -w_prod : w_prod);
                            r_pos[r_lvl] <= w_pos + 1'b1;
                            r_state      <= S_NODE;
                        end
                    end
                end
                S_RET: begin
                    if (r_lvl != '0) begin
                        r_lvl   <= r_lvl - 1'b1;
                        r_state <= S_RDA;
                    end else if (r_cof) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_det   <= r_val;
                        r_sing  <= (r_val == '0);
                        r_state <= (r_val == '0) ? S_EMIT : S_COF;
                    end
                end
                S_DIVW: begin
                    if (w_dstat.done) begin
                        r_q     <= w_dval;
                        r_qsat  <= w_dstat.sat;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot) begin
                        o_out_valid     <= 1'b1;
                        o_inverse_value <= r_sing ? '0 : OUT_W'(r_q);
                        o_saturated     <= r_sing ? 1'b0 : r_qsat;
                        o_singular      <= r_sing;
                        o_out_row       <= IDX_W'(r_orow);
                        o_out_col       <= IDX_W'(r_ocol);
                        o_last_result   <= w_olast;
                        if (w_olast) begin
                            r_orow  <= '0;
                            r_ocol  <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            if (r_ocol == RW'(DIM - 1)) begin
                                r_ocol <= '0;
                                r_orow <= r_orow + 1'b1;
                            end else begin
                                r_ocol <= r_ocol + 1'b1;
                            end
                            r_state <= r_sing ? S_EMIT : S_COF;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_LOAD);

    `MIC_ASSERT_IMP(a_mul_free, i_clk, i_rst_n, w_mstart, !w_mstat.busy)
    `MIC_ASSERT_IMP(a_mul_wait, i_clk, i_rst_n, w_mstat.done, r_state == S_MULW)
    `MIC_ASSERT_IMP(a_div_wait, i_clk, i_rst_n, w_dstat.done, r_state == S_DIVW)
    `MIC_ASSERT_IMP(a_sing_zero, i_clk, i_rst_n, o_out_valid && o_singular, o_inverse_value == '0 && !o_saturated)
    `MIC_ASSERT_NXT(a_last_load, i_clk, i_rst_n, r_state == S_EMIT && w_slot && w_olast, r_state == S_LOAD)

endmodule
